// ===== design/hash_set_membership_table_unit_defines.svh =====
// Assertion macros shared by the set table checker.
`ifndef HASH_SET_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH
`define HASH_SET_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define HSMT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define HSMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/hsmt_pkg.sv =====
// Types and constants of the set membership table.
`default_nettype none

package hsmt_pkg;

	// Table geometry; BUCKETS must be a power of two (bucket = low key bits).
	localparam int BUCKETS        = 16;
	localparam int WAYS           = 4;
	localparam int KEY_BITS       = 32;

	localparam int KEY_FIELD_BITS = 32;
	localparam int COUNT_OUT_BITS = 7;

	localparam int SLOTS          = BUCKETS * WAYS;
	localparam int KW             = (KEY_BITS < KEY_FIELD_BITS) ? KEY_BITS : KEY_FIELD_BITS;
	localparam int BUCKET_BITS    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WAY_BITS       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int CNT_RAW_BITS   = $clog2(SLOTS + 1);
	localparam int COUNT_BITS     = (CNT_RAW_BITS > COUNT_OUT_BITS) ? CNT_RAW_BITS
	                                                                : COUNT_OUT_BITS;
	localparam int ROW_BITS       = WAYS * KW;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_LOOKUP = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]                mode;
		logic [KEY_FIELD_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic                      was_present;
		logic                      bucket_full;
		logic [COUNT_OUT_BITS-1:0] member_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== design/hash_set_membership_table_unit.sv =====
// Bucketed hash set: key row memory, valid bit array and member counter.
`default_nettype none
// The request and its key row are registered on acceptance; the result is registered when it can post.
// A new request is taken only once the previous one has posted (key row read, then compare and write back).
// A request is taken while the previous result still waits in the output register.
// Reset clears all valid bits, the member count and the handshake state at once;
// the key memory is not cleared, as a way is only compared while its valid bit is set.

module hash_set_membership_table_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire hsmt_pkg::req_t in_req,
	output logic              out_valid,
	input  wire logic         out_ready,
	output hsmt_pkg::rsp_t    out_rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,  // waiting for a request
		ST_LOOK = 2'b10   // row data present: compare, update, post result
	} state_t;

	state_t state_q;

	// Request held for the compare stage
	logic [1:0]                      mode_s1;
	logic [hsmt_pkg::KW-1:0]         key_s1;
	logic [hsmt_pkg::BUCKET_BITS-1:0] bucket_s1;

	// Key row memory: one row per bucket, ways packed side by side
	logic [hsmt_pkg::ROW_BITS-1:0]   key_mem [hsmt_pkg::BUCKETS];
	logic [hsmt_pkg::ROW_BITS-1:0]   row_s1;

	// Valid bits kept in flops so reset can clear them in one go
	logic [hsmt_pkg::WAYS-1:0]       valid_q [hsmt_pkg::BUCKETS];
	logic [hsmt_pkg::COUNT_BITS-1:0] count_q;

	logic                            out_valid_q;
	hsmt_pkg::rsp_t                  out_rsp_q;

	logic                            accept;
	logic                            finish;
	logic [hsmt_pkg::KW-1:0]         key_in;
	logic [hsmt_pkg::BUCKET_BITS-1:0] bucket_in;

	logic [hsmt_pkg::WAYS-1:0]       vrow;
	logic                            hit;
	logic [hsmt_pkg::WAY_BITS-1:0]   hit_way;
	logic                            has_free;
	logic [hsmt_pkg::WAY_BITS-1:0]   free_way;
	logic                            do_add;
	logic                            do_del;
	logic                            full;
	logic [hsmt_pkg::ROW_BITS-1:0]   new_row;
	logic [hsmt_pkg::COUNT_BITS-1:0] count_nx;

	// ------------------------------------------------------------------
	// Handshake
	// ------------------------------------------------------------------
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	// Result can only be posted when the output register is free or draining
	assign finish    = (state_q == ST_LOOK) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// Keys wider than the table's key width are cut down; bucket is key mod BUCKETS
	assign key_in    = in_req.key[hsmt_pkg::KW-1:0];
	assign bucket_in = hsmt_pkg::BUCKET_BITS'({{hsmt_pkg::BUCKET_BITS{1'b0}}, key_in});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture alongside the row read
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= in_req.mode;
			key_s1    <= key_in;
			bucket_s1 <= bucket_in;
		end
	end

	// ------------------------------------------------------------------
	// Key memory: read on accept, written back at the end of the compare on an add.
	// One request in flight, so a read never meets a pending write.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1 <= key_mem[bucket_in];
		end
	end

	always_ff @(posedge clk) begin
		if (finish && do_add) begin
			key_mem[bucket_s1] <= new_row;
		end
	end

	// ------------------------------------------------------------------
	// Compare all ways; lowest matching valid way and lowest free way
	// ------------------------------------------------------------------
	always_comb begin
		vrow     = valid_q[bucket_s1];
		hit      = 1'b0;
		hit_way  = '0;
		has_free = 1'b0;
		free_way = '0;
		for (int w = 0; w < hsmt_pkg::WAYS; w++) begin
			if (vrow[w] && !hit && (row_s1[w*hsmt_pkg::KW +: hsmt_pkg::KW] == key_s1)) begin
				hit     = 1'b1;
				hit_way = hsmt_pkg::WAY_BITS'(w);
			end
			if (!vrow[w] && !has_free) begin
				has_free = 1'b1;
				free_way = hsmt_pkg::WAY_BITS'(w);
			end
		end
	end

	always_comb begin
		do_add = 1'b0;
		do_del = 1'b0;
		full   = 1'b0;
		unique case (mode_s1)
			hsmt_pkg::MODE_ADD: begin
				do_add = !hit && has_free;
				full   = !hit && !has_free;
			end
			hsmt_pkg::MODE_DELETE: begin
				do_del = hit;
			end
			default: begin
				// lookup, and the unused code behaves as a lookup
			end
		endcase
	end

	always_comb begin
		new_row = row_s1;
		new_row[free_way*hsmt_pkg::KW +: hsmt_pkg::KW] = key_s1;
	end

	always_comb begin
		count_nx = count_q;
		if (do_add) begin
			count_nx = count_q + hsmt_pkg::COUNT_BITS'(1);
		end else if (do_del) begin
			count_nx = count_q - hsmt_pkg::COUNT_BITS'(1);
		end
	end

	// ------------------------------------------------------------------
	// Valid bits and member count
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < hsmt_pkg::BUCKETS; b++) begin
				valid_q[b] <= '0;
			end
			count_q <= '0;
		end else if (finish) begin
			if (do_add) begin
				valid_q[bucket_s1][free_way] <= 1'b1;
			end else if (do_del) begin
				valid_q[bucket_s1][hit_way] <= 1'b0;
			end
			count_q <= count_nx;
		end
	end

	// ------------------------------------------------------------------
	// Output register: parts the compare stage from the consumer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_rsp_q.was_present  <= hit;
			out_rsp_q.bucket_full  <= full;
			out_rsp_q.member_count <= count_nx[hsmt_pkg::COUNT_OUT_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== design/hsmt_checker.sv =====
// Port-level checks for the set membership table, bound to the table unit module.
`default_nettype none
`include "hash_set_membership_table_unit_defines.svh"

module hsmt_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire hsmt_pkg::req_t in_req,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire hsmt_pkg::rsp_t out_rsp
);

	logic in_acc;
	logic in_wait;
	logic out_stall;
	logic rsp_bad_flags;

	assign in_acc        = in_valid && in_ready;
	assign in_wait       = in_valid && !in_ready;
	assign out_stall     = out_valid && !out_ready;
	assign rsp_bad_flags = out_rsp.bucket_full && out_rsp.was_present;

	`HSMT_ASSERT_NEXT(a_rsp_held, out_stall, out_valid && $stable(out_rsp), "stalled response changed")
	`HSMT_ASSERT_NEXT(a_req_held, in_wait, in_valid && $stable(in_req), "waiting request changed")
	`HSMT_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready, "request taken while one in flight")
	`HSMT_ASSERT_IMPL(a_full_not_present, out_valid, !rsp_bad_flags, "full flag on a present key")
	`HSMT_ASSERT_IMPL(a_rsp_from_req, $rose(out_valid), !$past(in_ready), "response without request")

endmodule

bind hash_set_membership_table_unit hsmt_checker u_hsmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_req    (in_req),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_rsp   (out_rsp)
);

`default_nettype wire

// ===== verif/hash_set_membership_table_unit_checker.sv =====
// Shadow set model and result comparison for the set membership table.
`timescale 1ns / 100ps

module hash_set_membership_table_checker
	import hsmt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_ready,
	input  wire req_t    in_req,
	input  wire logic    out_valid,
	input  wire logic    out_ready,
	input  wire rsp_t    out_rsp,
	output int unsigned  fail_count,
	output int           pending_results
);

	localparam logic [KEY_FIELD_BITS-1:0] KEY_MASK = KEY_FIELD_BITS'((64'd1 << KW) - 64'd1);

	logic [KEY_FIELD_BITS-1:0] shadow_key [SLOTS];
	bit                        shadow_used [SLOTS];
	int                        shadow_members;
	rsp_t                      awaited_rsp [$];

	// Applies one request to the shadow table and returns the result it owes.
	function automatic rsp_t predict_membership(req_t req);
		logic [KEY_FIELD_BITS-1:0] k;
		int base;
		int hit;
		int free_way;
		bit full;
		rsp_t r;
		k = req.key & KEY_MASK;
		base = int'(64'(k) % 64'(BUCKETS)) * WAYS;
		hit = -1;
		free_way = -1;
		full = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (shadow_used[base + w]) begin
				if (hit < 0 && shadow_key[base + w] == k)
					hit = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		if (req.mode == MODE_ADD) begin
			if (hit < 0) begin
				if (free_way >= 0) begin
					shadow_key[base + free_way] = k;
					shadow_used[base + free_way] = 1'b1;
					shadow_members++;
				end else begin
					full = 1'b1;
				end
			end
		end else if (req.mode == MODE_DELETE) begin
			if (hit >= 0) begin
				shadow_used[base + hit] = 1'b0;
				if (shadow_members > 0)
					shadow_members--;
			end
		end
		// anything else, the unused code included, is a plain lookup
		r = '0;
		r.was_present = (hit >= 0);
		r.bucket_full = full;
		r.member_count = COUNT_OUT_BITS'(shadow_members);
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			for (int s = 0; s < SLOTS; s++) begin
				shadow_key[s] = '0;
				shadow_used[s] = 1'b0;
			end
			shadow_members = 0;
			awaited_rsp.delete();
			fail_count = 0;
			pending_results = 0;
		end else begin
			if (in_valid && in_ready)
				awaited_rsp = {awaited_rsp, predict_membership(in_req)};
			if (out_valid && out_ready) begin
				if (awaited_rsp.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					exp_rsp = awaited_rsp.pop_front();
					if (out_rsp.was_present !== exp_rsp.was_present)
						report_mismatch($sformatf("was_present %b, expected %b",
							out_rsp.was_present, exp_rsp.was_present));
					if (out_rsp.bucket_full !== exp_rsp.bucket_full)
						report_mismatch($sformatf("bucket_full %b, expected %b",
							out_rsp.bucket_full, exp_rsp.bucket_full));
					if (out_rsp.member_count !== exp_rsp.member_count)
						report_mismatch($sformatf("member_count %0d, expected %0d",
							out_rsp.member_count, exp_rsp.member_count));
				end
			end
			pending_results = awaited_rsp.size();
		end
	end

endmodule

// ===== verif/tb_hash_set_membership_table_unit.sv =====
// Top of the set membership table testbench: clock, reset, requests and verdict.
`timescale 1ns / 100ps

module tb_hash_set_membership_table_unit;
	import hsmt_pkg::*;

	localparam int         CYCLE_LIMIT     = 200000;
	// the mode field has one code that the enum leaves out; it must act as a lookup
	localparam logic [1:0] MODE_SPARE      = 2'd3;
	localparam int         KEYS_PER_BUCKET = 6;  // more than WAYS, so buckets overflow
	localparam int         POOL_SIZE       = BUCKETS * KEYS_PER_BUCKET;
	localparam int         RANDOM_ITEMS    = 1450;

	logic        clk;
	logic        arst_n;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	req_t        in_req    = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rsp_t        out_rsp;

	int unsigned fail_count;
	int          pending_results;
	int          cycle_count = 0;
	bit          steady      = 1'b0;  // high: neither side inserts gaps
	logic [31:0] key_pool [POOL_SIZE];

	hash_set_membership_table_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp)
	);

	hash_set_membership_table_checker set_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_req          (in_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_rsp         (out_rsp),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: ready drops in roughly a third of cycles unless in a steady stretch.
	always @(negedge clk)
		out_ready <= arst_n && (steady || $urandom_range(0, 99) >= 34);

	function automatic bit take_gap();
		return !steady && ($urandom_range(0, 99) < 34);
	endfunction

	// Stage 1 fills the table towards its full count, stage 2 drains it,
	// stage 0 is a mix of all modes.
	function automatic logic [1:0] pick_mode(int stage);
		int roll;
		int add_pct;
		int del_pct;
		roll = $urandom_range(0, 99);
		case (stage)
			1: begin
				add_pct = 70;
				del_pct = 10;
			end
			2: begin
				add_pct = 10;
				del_pct = 70;
			end
			default: begin
				add_pct = 40;
				del_pct = 30;
			end
		endcase
		if (roll < add_pct)
			return MODE_ADD;
		else if (roll < add_pct + del_pct)
			return MODE_DELETE;
		else if (roll < 95)
			return MODE_LOOKUP;
		else
			return MODE_SPARE;
	endfunction

	// Mostly keys from the pool so that duplicates, hits and full buckets are common;
	// now and then a fresh key from the whole range.
	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 99) < 12)
			return $urandom();
		else
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	// Called just after a falling edge; returns just after the falling edge
	// that follows acceptance, with in_valid still high.
	task automatic push_request(input logic [1:0] op, input logic [31:0] key);
		req_t r;
		r.mode = op;
		r.key = key;
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Sender stops until every request so far has been answered.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
	endtask

	initial begin
		arst_n = 1'b0;

		// Pool keys: random upper bits, every bucket covered evenly.
		for (int b = 0; b < BUCKETS; b++)
			for (int j = 0; j < KEYS_PER_BUCKET; j++)
				key_pool[b * KEYS_PER_BUCKET + j] = ($urandom() / BUCKETS) * BUCKETS + b;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ---- directed requests ----
		push_request(MODE_LOOKUP, 32'h0000_0000);            // lookup on an empty set
		push_request(MODE_ADD,    32'h0000_0000);            // lowest key
		push_request(MODE_ADD,    32'hFFFF_FFFF);            // highest key
		push_request(MODE_ADD,    32'h0000_0000);            // duplicate add
		// fill every way of one bucket, then overflow it
		push_request(MODE_ADD,    32'(5));
		push_request(MODE_ADD,    32'(5 + BUCKETS));
		push_request(MODE_ADD,    32'(5 + 2 * BUCKETS));
		push_request(MODE_ADD,    32'(5 + 3 * BUCKETS));
		push_request(MODE_ADD,    32'(5 + 4 * BUCKETS));     // rejected, bucket full
		push_request(MODE_LOOKUP, 32'(5 + 4 * BUCKETS));     // must not be there
		push_request(MODE_ADD,    32'(5 + 3 * BUCKETS));     // duplicate in a full bucket
		push_request(MODE_DELETE, 32'(5 + BUCKETS));         // frees a middle way
		push_request(MODE_DELETE, 32'(5 + BUCKETS));         // delete of an absent key
		push_request(MODE_ADD,    32'(5 + 4 * BUCKETS));     // reuses the freed way
		push_request(MODE_DELETE, 32'(5));                   // head of the bucket
		push_request(MODE_LOOKUP, 32'(5 + 2 * BUCKETS));     // rest of the bucket survives
		push_request(MODE_SPARE,  32'(5 + 3 * BUCKETS));     // unused code: lookup, hit
		push_request(MODE_SPARE,  32'h1234_5678);            // unused code: lookup, miss
		push_request(MODE_DELETE, 32'hFFFF_FFFF);
		push_request(MODE_DELETE, 32'h0000_0000);
		push_request(MODE_LOOKUP, 32'hAAAA_AAAA);
		push_request(MODE_ADD,    32'h5555_5555);
		push_request(MODE_LOOKUP, 32'h5555_5555);

		hold_until_drained();

		// ---- random requests ----
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 400)
				hold_until_drained();
			if (i == 700)
				steady <= 1'b1;
			if (i == 1000)
				steady <= 1'b0;
			push_request(pick_mode((i / 150) % 3), pick_key());
		end

		// ---- wind-down: wait for outstanding results, then idle before the verdict ----
		in_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending_results == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== hash_set_membership_table_unit.f =====
+incdir+design
design/hsmt_pkg.sv
design/hash_set_membership_table_unit.sv
design/hsmt_checker.sv
verif/hash_set_membership_table_unit_checker.sv
verif/tb_hash_set_membership_table_unit.sv
